/* hdl/dasd_pkg.sv */
`timescale 1ns / 1ps
package dasd_pkg;

  localparam int MAX_FRAMES_DEF   = 4096;
  localparam int MAX_CHANNELS_DEF = 2;
  localparam int QUEUE_DEPTH      = 4;

  localparam int SAMPLE_W  = 16;
  localparam int THRESH_W  = 31;
  localparam int COUNT_W   = 32;
  localparam int CHCNT_W   = 2;
  localparam int ENERGY_W  = 44;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE             = 3'd0,
    REG_THRESHOLD_SQ       = 3'd1,
    REG_SKIP_TIMEOUT       = 3'd2,
    REG_FALLBACK_TIMEOUT   = 3'd3,
    REG_CHANNEL_COUNT      = 3'd4,
    REG_FALLBACK_AVAILABLE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                enable;
    logic [THRESH_W-1:0] threshold_sq;
    logic [COUNT_W-1:0]  skip_timeout;
    logic [COUNT_W-1:0]  fallback_timeout;
    logic [CHCNT_W-1:0]  channel_count;
    logic                fallback_available;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enable:             1'b1,
    threshold_sq:       31'd10737,
    skip_timeout:       32'd720000,
    fallback_timeout:   32'd1440000,
    channel_count:      2'd2,
    fallback_available: 1'b0
  };

  // Stereo only when the count says two or more and the build has room for it.
  function automatic logic dual_ch(input logic [CHCNT_W-1:0] cc, input int max_ch);
    return (max_ch >= 2) && cc[1];
  endfunction

  // Saturating counter add.
  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

endpackage

/* hdl/dasd_if.sv */
`timescale 1ns / 1ps
interface dasd_frame_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dasd_pkg::SAMPLE_W-1:0]  sample_left;
  logic signed [dasd_pkg::SAMPLE_W-1:0]  sample_right;
  logic                                  buffer_end;
  modport source (output valid, sample_left, sample_right, buffer_end, input ready);
  modport sink   (input valid, sample_left, sample_right, buffer_end, output ready);
endinterface

interface dasd_result_if;
  logic                           valid;
  logic                           ready;
  logic                           silent;
  logic                           skip_track;
  logic                           load_fallback;
  logic                           dead_air;
  logic [dasd_pkg::COUNT_W-1:0]   silent_frames;
  logic [dasd_pkg::ENERGY_W-1:0]  buffer_energy;
  modport source (output valid, silent, skip_track, load_fallback, dead_air,
                  silent_frames, buffer_energy, input ready);
  modport sink   (input valid, silent, skip_track, load_fallback, dead_air,
                  silent_frames, buffer_energy, output ready);
endinterface

interface dasd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dasd_pkg::CFG_IDX_W-1:0]  index;
  logic [dasd_pkg::CFG_DAT_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/dead_air_silence_detector_unit.sv */
`timescale 1ns / 1ps
// Dead-air silence detector.
// in_frame : one PCM frame per request (left, right, buffer_end). While the
//            detector is disabled frames are taken and dropped.
// out_result: one request per finished buffer (buffer_end seen, or the
//            buffer reached MAX_FRAMES frames): silent verdict, skip and
//            fallback actions, dead-air mark, silent frame count, energy.
// cfg_wr   : register writes, always ready; write only while idle.
// Throughput: one frame per cycle while the queue has room. A front pipe squares and accumulates;
//   closed buffers go through a 4-entry queue to a back pipe that forms
//   threshold * frames * channels (one multiplier) and updates the counters.
// Path: a closing frame's squares load stage A as it is taken, then the
//   closed buffer is written to the queue, and the limit reg and the output
//   reg load in turn.
// Reset: registers return to their defaults, buffer and counters clear.
// Stalls: a result waits in the output register; the queue absorbs further
//   buffers and in_frame.ready drops only once the queue is nearly full.
module dead_air_silence_detector_unit #(
  parameter int MAX_FRAMES   = dasd_pkg::MAX_FRAMES_DEF,
  parameter int MAX_CHANNELS = dasd_pkg::MAX_CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  dasd_frame_if.sink    in_frame,
  dasd_result_if.source out_result,
  dasd_cfg_if.sink      cfg_wr
);
  import dasd_pkg::*;

  localparam int FW = $clog2(MAX_FRAMES+1);
  localparam int EW = $clog2(MAX_FRAMES*MAX_CHANNELS) + 31;
  localparam int RW = FW + EW;

  cfg_t cfg_r;

  logic                             q_push, q_pop, q_valid;
  logic [RW-1:0]                    q_wdata, q_rdata;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_level;

  // Config register file.
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr.valid) begin
      case (cfg_reg_t'(cfg_wr.index))
        REG_ENABLE:             cfg_r.enable             <= cfg_wr.data[0];
        REG_THRESHOLD_SQ:       cfg_r.threshold_sq       <= cfg_wr.data[THRESH_W-1:0];
        REG_SKIP_TIMEOUT:       cfg_r.skip_timeout       <= cfg_wr.data[COUNT_W-1:0];
        REG_FALLBACK_TIMEOUT:   cfg_r.fallback_timeout   <= cfg_wr.data[COUNT_W-1:0];
        REG_CHANNEL_COUNT:      cfg_r.channel_count      <= cfg_wr.data[CHCNT_W-1:0];
        REG_FALLBACK_AVAILABLE: cfg_r.fallback_available <= cfg_wr.data[0];
        default: ; // unmapped index, ignored
      endcase
    end
  end

  dasd_front #(
    .MAX_FRAMES   (MAX_FRAMES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .QDEPTH       (QUEUE_DEPTH),
    .FW           (FW),
    .EW           (EW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .frame   (in_frame),
    .q_level (q_level),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  // Closed buffers: {frame count, energy}.
  dasd_fifo #(
    .W     (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata),
    .level     (q_level)
  );

  dasd_back #(
    .MAX_FRAMES   (MAX_FRAMES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .FW           (FW),
    .EW           (EW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .result  (out_result)
  );

endmodule

/* hdl/dasd_fifo.sv */
`timescale 1ns / 1ps
module dasd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               push_data,
  input  logic                       pop,
  output logic                       pop_valid,
  output logic [W-1:0]               pop_data,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH+1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [LW-1:0] level_r;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      level_r <= level_r + 1'b1;
      else if (pop && !push) level_r <= level_r - 1'b1;
    end
  end

  assign pop_valid = (level_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign level     = level_r;

endmodule

/* hdl/dasd_front.sv */
`timescale 1ns / 1ps
module dasd_front #(
  parameter int MAX_FRAMES   = dasd_pkg::MAX_FRAMES_DEF,
  parameter int MAX_CHANNELS = dasd_pkg::MAX_CHANNELS_DEF,
  parameter int QDEPTH       = dasd_pkg::QUEUE_DEPTH,
  parameter int FW           = $clog2(MAX_FRAMES+1),
  parameter int EW           = $clog2(MAX_FRAMES*MAX_CHANNELS) + 31
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dasd_pkg::cfg_t              cfg,
  dasd_frame_if.sink                  frame,
  input  logic [$clog2(QDEPTH+1)-1:0] q_level,
  output logic                        q_push,
  output logic [FW+EW-1:0]            q_data
);
  import dasd_pkg::*;

  localparam int LVW = $clog2(QDEPTH+1) + 1;
  localparam int SQW = 2*SAMPLE_W - 1;

  // Stage A: registered squares.
  logic           a_valid_r;
  logic           a_end_r;
  logic [SQW-1:0] a_sql_r, a_sqr_r;

  // Stage B: buffer accumulator.
  logic [EW-1:0] energy_r;
  logic [FW-1:0] frames_r;

  logic                         accept;
  logic signed [2*SAMPLE_W-1:0] sq_l, sq_r;
  logic [EW-1:0]                energy_nxt;
  logic [FW-1:0]                frames_nxt;
  logic                         close;

  // Room for the frame in stage A plus one more closing frame.
  assign frame.ready = ({1'b0, q_level} + LVW'(a_valid_r)) < LVW'(QDEPTH);
  assign accept      = frame.valid && frame.ready;

  assign sq_l = frame.sample_left * frame.sample_left;
  assign sq_r = frame.sample_right * frame.sample_right;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept && cfg.enable;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_end_r <= frame.buffer_end;
      a_sql_r <= sq_l[SQW-1:0];
      a_sqr_r <= dual_ch(cfg.channel_count, MAX_CHANNELS) ? sq_r[SQW-1:0] : '0;
    end
  end

  assign energy_nxt = energy_r + EW'(a_sql_r) + EW'(a_sqr_r);
  assign frames_nxt = frames_r + 1'b1;
  // Full buffer closes on its own.
  assign close      = a_valid_r && (a_end_r || (frames_nxt == FW'(MAX_FRAMES)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= '0;
      frames_r <= '0;
    end else if (a_valid_r) begin
      energy_r <= close ? '0 : energy_nxt;
      frames_r <= close ? '0 : frames_nxt;
    end
  end

  assign q_push = close;
  assign q_data = {frames_nxt, energy_nxt};

endmodule

/* hdl/dasd_back.sv */
`timescale 1ns / 1ps
module dasd_back #(
  parameter int MAX_FRAMES   = dasd_pkg::MAX_FRAMES_DEF,
  parameter int MAX_CHANNELS = dasd_pkg::MAX_CHANNELS_DEF,
  parameter int FW           = $clog2(MAX_FRAMES+1),
  parameter int EW           = $clog2(MAX_FRAMES*MAX_CHANNELS) + 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dasd_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  logic [FW+EW-1:0]  q_data,
  output logic              q_pop,
  dasd_result_if.source     result
);
  import dasd_pkg::*;

  localparam int LW = THRESH_W + FW + 1;
  localparam int CW = (EW > LW) ? EW : LW;

  // Stage 1: limit = threshold_sq * frames * channels.
  logic          s1_valid_r;
  logic [EW-1:0] s1_energy_r;
  logic [FW-1:0] s1_frames_r;
  logic [LW-1:0] s1_limit_r;

  // Silence tracking state.
  logic [COUNT_W-1:0] silence_cnt_r, post_skip_r;
  logic               skip_fired_r, dead_air_r;

  // Output register.
  logic                o_valid_r;
  logic                o_silent_r, o_skip_r, o_fb_r, o_dead_r;
  logic [COUNT_W-1:0]  o_frames_r;
  logic [ENERGY_W-1:0] o_energy_r;

  logic          o_adv, s1_adv;
  logic [FW-1:0] q_frames;
  logic [EW-1:0] q_energy;
  logic [FW:0]   samples;
  logic [LW-1:0] limit_nxt;

  logic               silent;
  logic               skip, fallback, fired_nxt, dead_nxt;
  logic [COUNT_W-1:0] sil_nxt, post_nxt, post_base;

  assign o_adv  = !o_valid_r || result.ready;
  assign s1_adv = s1_valid_r && o_adv;
  assign q_pop  = q_valid && (!s1_valid_r || o_adv);

  assign {q_frames, q_energy} = q_data;
  assign samples   = dual_ch(cfg.channel_count, MAX_CHANNELS) ? {q_frames, 1'b0}
                                                             : {1'b0, q_frames};
  assign limit_nxt = LW'(cfg.threshold_sq) * LW'(samples);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (q_pop) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_energy_r <= q_energy;
      s1_frames_r <= q_frames;
      s1_limit_r  <= limit_nxt;
    end
  end

  // Buffer verdict and timeout bookkeeping.
  always_comb begin
    silent    = CW'(s1_energy_r) < CW'(s1_limit_r);
    skip      = 1'b0;
    fallback  = 1'b0;
    sil_nxt   = '0;
    post_nxt  = '0;
    post_base = '0;
    fired_nxt = 1'b0;
    dead_nxt  = 1'b0;
    if (silent) begin
      sil_nxt   = sat_add(silence_cnt_r, COUNT_W'(s1_frames_r));
      skip      = !skip_fired_r && (sil_nxt >= cfg.skip_timeout);
      fired_nxt = skip_fired_r || skip;
      dead_nxt  = dead_air_r || skip;
      post_base = skip ? '0 : post_skip_r;
      post_nxt  = post_base;
      if (fired_nxt) begin
        post_nxt = sat_add(post_base, COUNT_W'(s1_frames_r));
        if ((post_nxt >= cfg.fallback_timeout) && cfg.fallback_available) begin
          fallback  = 1'b1;
          fired_nxt = 1'b0;
          sil_nxt   = '0;
          post_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_cnt_r <= '0;
      post_skip_r   <= '0;
      skip_fired_r  <= 1'b0;
      dead_air_r    <= 1'b0;
      o_valid_r     <= 1'b0;
    end else begin
      if (s1_adv) begin
        silence_cnt_r <= sil_nxt;
        post_skip_r   <= post_nxt;
        skip_fired_r  <= fired_nxt;
        dead_air_r    <= dead_nxt;
        o_valid_r     <= 1'b1;
      end else if (result.ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_silent_r <= silent;
      o_skip_r   <= skip;
      o_fb_r     <= fallback;
      o_dead_r   <= dead_nxt;
      o_frames_r <= sil_nxt;
      o_energy_r <= ENERGY_W'(s1_energy_r);
    end
  end

  assign result.valid         = o_valid_r;
  assign result.silent        = o_silent_r;
  assign result.skip_track    = o_skip_r;
  assign result.load_fallback = o_fb_r;
  assign result.dead_air      = o_dead_r;
  assign result.silent_frames = o_frames_r;
  assign result.buffer_energy = o_energy_r;

endmodule

/* tb/sv/silence_verdict_checker.sv */
`timescale 1ns / 1ps
module silence_verdict_checker (
  input  logic   clk,
  input  logic   rst_n,
  dasd_frame_if  frm,
  dasd_result_if res,
  dasd_cfg_if    cfg,
  output int     mismatches,
  output int     verdicts_due
);
  import dasd_pkg::*;

  typedef struct {
    logic                silent;
    logic                skip_track;
    logic                load_fallback;
    logic                dead_air;
    logic [COUNT_W-1:0]  silent_frames;
    logic [ENERGY_W-1:0] buffer_energy;
  } verdict_t;

  verdict_t           expected_verdicts[$];
  cfg_t               regs;
  logic [63:0]        energy_acc;
  int unsigned        frames_acc;
  logic [COUNT_W-1:0] quiet_run;
  logic [COUNT_W-1:0] after_skip;
  logic               skip_armed;   // skip fired, fallback not yet
  logic               dead_mark;
  int                 errs;

  initial begin
    mismatches   = 0;
    verdicts_due = 0;
    errs         = 0;
  end

  // Counter add that sticks at all ones.
  function automatic logic [COUNT_W-1:0] add_clamped(logic [COUNT_W-1:0] a,
                                                     int unsigned b);
    longint unsigned total;
    total = longint'(a) + longint'(b);
    if (total > 64'hFFFF_FFFF) return '1;
    return total[COUNT_W-1:0];
  endfunction

  function automatic void predict_frame(logic signed [SAMPLE_W-1:0] l,
                                        logic signed [SAMPLE_W-1:0] r,
                                        logic last);
    int unsigned nch;
    longint      sq;
    logic [63:0] limit_sq;
    verdict_t    v;
    if (!regs.enable) return;
    nch = (regs.channel_count <= 1) ? 1 : 2;
    if (nch > MAX_CHANNELS_DEF) nch = MAX_CHANNELS_DEF;
    sq = longint'(l) * longint'(l);
    energy_acc += sq;
    if (nch == 2) begin
      sq = longint'(r) * longint'(r);
      energy_acc += sq;
    end
    frames_acc++;
    if (!last && frames_acc < MAX_FRAMES_DEF) return;

    limit_sq        = 64'(regs.threshold_sq) * 64'(frames_acc * nch);
    v.silent        = 1'b0;
    v.skip_track    = 1'b0;
    v.load_fallback = 1'b0;
    if (energy_acc < limit_sq) begin
      v.silent  = 1'b1;
      quiet_run = add_clamped(quiet_run, frames_acc);
      if (!skip_armed && quiet_run >= regs.skip_timeout) begin
        dead_mark    = 1'b1;
        skip_armed   = 1'b1;
        after_skip   = '0;
        v.skip_track = 1'b1;
      end
      if (skip_armed) begin
        after_skip = add_clamped(after_skip, frames_acc);
        if (after_skip >= regs.fallback_timeout && regs.fallback_available) begin
          v.load_fallback = 1'b1;
          skip_armed      = 1'b0;
          quiet_run       = '0;
          after_skip      = '0;
        end
      end
    end else begin
      quiet_run  = '0;
      after_skip = '0;
      skip_armed = 1'b0;
      dead_mark  = 1'b0;
    end
    v.dead_air      = dead_mark;
    v.silent_frames = quiet_run;
    v.buffer_energy = energy_acc[ENERGY_W-1:0];
    expected_verdicts.push_back(v);
    energy_acc = '0;
    frames_acc = 0;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errs++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      regs       = CFG_RESET;
      energy_acc = '0;
      frames_acc = 0;
      quiet_run  = '0;
      after_skip = '0;
      skip_armed = 1'b0;
      dead_mark  = 1'b0;
      expected_verdicts.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_ENABLE:             regs.enable             = cfg.data[0];
          REG_THRESHOLD_SQ:       regs.threshold_sq       = cfg.data[THRESH_W-1:0];
          REG_SKIP_TIMEOUT:       regs.skip_timeout       = cfg.data;
          REG_FALLBACK_TIMEOUT:   regs.fallback_timeout   = cfg.data;
          REG_CHANNEL_COUNT:      regs.channel_count      = cfg.data[CHCNT_W-1:0];
          REG_FALLBACK_AVAILABLE: regs.fallback_available = cfg.data[0];
          default: ;
        endcase
      end
      if (frm.valid && frm.ready)
        predict_frame(frm.sample_left, frm.sample_right, frm.buffer_end);
      if (res.valid && res.ready) begin
        if (expected_verdicts.size() == 0) begin
          errs++;
          $display("%0t: result with none pending, expected nothing actual silent=%0b skip=%0b fb=%0b dead=%0b frames=%0h energy=%0h",
                   $time, res.silent, res.skip_track, res.load_fallback, res.dead_air,
                   res.silent_frames, res.buffer_energy);
        end else begin
          v = expected_verdicts.pop_front();
          check_field("silent", v.silent, res.silent);
          check_field("skip_track", v.skip_track, res.skip_track);
          check_field("load_fallback", v.load_fallback, res.load_fallback);
          check_field("dead_air", v.dead_air, res.dead_air);
          check_field("silent_frames", v.silent_frames, res.silent_frames);
          check_field("buffer_energy", v.buffer_energy, res.buffer_energy);
        end
      end
    end
    mismatches   <= errs;
    verdicts_due <= expected_verdicts.size();
  end

endmodule

/* tb/sv/tb_dead_air_silence_detector_unit.sv */
`timescale 1ns / 1ps
module tb_dead_air_silence_detector_unit;
  import dasd_pkg::*;

  localparam int DRAIN_CYCLES  = 12;    // margin for the block to drain its pipe
  localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int RANDOM_FRAMES = 1400;
  localparam int HOLD_CYCLES   = 600;   // long receiver hold-off

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       last;
  } pcm_frame_t;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   verdicts_due;
  int   hold_off;

  pcm_frame_t frames_to_send[$];

  dasd_frame_if  in_frame();
  dasd_result_if out_result();
  dasd_cfg_if    cfg_wr();

  dead_air_silence_detector_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_frame   (in_frame),
    .out_result (out_result),
    .cfg_wr     (cfg_wr)
  );

  silence_verdict_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frm          (in_frame),
    .res          (out_result),
    .cfg          (cfg_wr),
    .mismatches   (mismatches),
    .verdicts_due (verdicts_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Frame sender: pops queued frames, works in bursts with gaps between.
  // A new request is only loaded once the current one has been taken.
  // ---------------------------------------------------------------------
  initial begin
    int         burst_left;
    int         gap_left;
    pcm_frame_t f;
    in_frame.valid        = 1'b0;
    in_frame.sample_left  = '0;
    in_frame.sample_right = '0;
    in_frame.buffer_end   = 1'b0;
    burst_left = 1;
    gap_left   = 0;
    forever begin
      @(posedge clk);
      if (!in_frame.valid || in_frame.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_frame.valid <= 1'b0;
        end else if (frames_to_send.size() != 0) begin
          f = frames_to_send.pop_front();
          in_frame.valid        <= 1'b1;
          in_frame.sample_left  <= f.left;
          in_frame.sample_right <= f.right;
          in_frame.buffer_end   <= f.last;
          burst_left--;
          if (burst_left <= 0) begin
            // now and then a long burst with no idling at all
            if ($urandom_range(0, 9) == 0) begin
              burst_left = $urandom_range(100, 300);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 48);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
          end
        end else begin
          in_frame.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result receiver: ready follows a stall pattern picked per stretch.
  // hold_off forces ready low for a counted number of cycles.
  // ---------------------------------------------------------------------
  initial begin
    rx_mode_t mode;
    int       stretch;
    int       tick;
    out_result.ready = 1'b0;
    mode    = RX_OPEN;
    stretch = 0;
    tick    = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (stretch == 0) begin
        mode    = rx_mode_t'($urandom_range(0, 3));
        stretch = $urandom_range(16, 160);
      end
      stretch--;
      if (hold_off > 0) begin
        hold_off--;
        out_result.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   out_result.ready <= 1'b1;
          RX_COIN:   out_result.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_result.ready <= ($urandom_range(0, 3) == 0);
          default:   out_result.ready <= (tick % 7 != 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run if nothing moves on any channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_frame.valid && in_frame.ready) || (out_result.valid && out_result.ready) ||
          (cfg_wr.valid && cfg_wr.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic logic signed [SAMPLE_W-1:0] rand_sample(int cap);
    int v;
    if (cap >= 32767) return SAMPLE_W'($urandom);   // full range, -32768 included
    v = int'($urandom_range(0, 2 * cap)) - cap;
    return v[SAMPLE_W-1:0];
  endfunction

  // Amplitude cap per buffer; the small ones give silent buffers for most
  // thresholds, the large ones audio.
  function automatic int pick_cap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 4) return 0;
    if (r < 8) return 4;
    if (r < 12) return 40;
    if (r < 15) return 300;
    if (r < 17) return 3000;
    return 32767;
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 12);
    if (r < 97) return $urandom_range(13, 64);
    return $urandom_range(65, 300);
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'h4000_0000;
      2, 3:    return $urandom_range(0, 20000);
      default: return $urandom_range(0, 32'h4000_0000);
    endcase
  endfunction

  // Timeouts: mostly short so skip and fallback fire often.
  function automatic logic [CFG_DAT_W-1:0] pick_timeout();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 80);
    endcase
  endfunction

  task automatic push(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                      logic last);
    pcm_frame_t f;
    f.left  = l;
    f.right = r;
    f.last  = last;
    frames_to_send.push_back(f);
  endtask

  // len frames of random samples; closed puts buffer_end on the final one
  task automatic push_buffer(int len, int cap, bit closed);
    for (int i = 0; i < len; i++)
      push(rand_sample(cap), rand_sample(cap), closed && (i == len - 1));
  endtask

  // Wait until every frame is taken and every result has come back, then
  // give the block time to finish a buffer that yields no result.
  task automatic settle();
    while (frames_to_send.size() != 0 || in_frame.valid || verdicts_due != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes; last drops it
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] val, bit last);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= val;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    if (last) cfg_wr.valid <= 1'b0;
  endtask

  task automatic load_settings(bit en, logic [CFG_DAT_W-1:0] thr,
                               logic [CFG_DAT_W-1:0] skip_to,
                               logic [CFG_DAT_W-1:0] fb_to,
                               logic [CFG_DAT_W-1:0] ch, bit fb_ok);
    write_reg(REG_ENABLE, CFG_DAT_W'(en), 1'b0);
    write_reg(REG_THRESHOLD_SQ, thr, 1'b0);
    write_reg(REG_SKIP_TIMEOUT, skip_to, 1'b0);
    write_reg(REG_FALLBACK_TIMEOUT, fb_to, 1'b0);
    write_reg(REG_CHANNEL_COUNT, ch, 1'b0);
    write_reg(REG_FALLBACK_AVAILABLE, CFG_DAT_W'(fb_ok), 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int sent;
    int phase;
    int target;
    int got;
    int len;
    bit open_end;
    rst_n        = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = '0;
    cfg_wr.data  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: sample extremes, short timeouts, fallback on
    load_settings(1'b1, 10737, 3, 2, 2, 1'b1);
    push(16'sh7FFF, -16'sh8000, 1'b1);
    push(-16'sh8000, 16'sh7FFF, 1'b1);
    // silent run: skip at 3 frames, fallback one frame later (2 counted from the skip buffer), dead air holds
    push(0, 0, 1'b0);
    push(0, 0, 1'b1);
    push(1, -1, 1'b1);
    push(0, 0, 1'b1);
    push(0, 0, 1'b1);
    push(500, -500, 1'b1);   // audio clears everything

    // skip and fallback together in one buffer
    settle();
    write_reg(REG_SKIP_TIMEOUT, 0, 1'b0);
    write_reg(REG_FALLBACK_TIMEOUT, 1, 1'b1);
    push(0, 0, 1'b1);

    // odd channel counts: 0 acts as mono, 3 as stereo
    settle();
    write_reg(REG_CHANNEL_COUNT, 0, 1'b1);
    push(0, 16'sh7FFF, 1'b1);
    settle();
    write_reg(REG_CHANNEL_COUNT, 3, 1'b1);
    push(0, 16'sh7FFF, 1'b1);

    // channel count changed with a buffer half gathered
    settle();
    write_reg(REG_CHANNEL_COUNT, 1, 1'b1);
    push(100, 16'sh7FFF, 1'b0);
    settle();
    write_reg(REG_CHANNEL_COUNT, 2, 1'b1);
    push(0, 0, 1'b1);

    // disabled: frames dropped, open buffer untouched
    push(7, 7, 1'b0);
    settle();
    write_reg(REG_ENABLE, 0, 1'b1);
    push(16'sh7FFF, 16'sh7FFF, 1'b1);
    push(-16'sh8000, 16'sh7FFF, 1'b0);
    settle();
    write_reg(REG_ENABLE, 1, 1'b1);
    push(0, 0, 1'b1);

    // threshold extremes; full-scale equal to the limit is not silent
    settle();
    write_reg(REG_THRESHOLD_SQ, 0, 1'b1);
    push(0, 0, 1'b1);
    settle();
    write_reg(REG_THRESHOLD_SQ, 32'h4000_0000, 1'b1);
    push(-16'sh8000, -16'sh8000, 1'b1);
    push(16'sh7FFF, 16'sh7FFF, 1'b1);

    // skip with no fallback source, then the largest timeouts
    settle();
    load_settings(1'b1, 10737, 0, 0, 2, 1'b0);
    push(0, 0, 1'b1);
    push(0, 0, 1'b1);
    settle();
    load_settings(1'b1, 10737, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 1'b1);
    push(0, 0, 1'b1);

    // full buffer: MAX_FRAMES frames close it without buffer_end
    settle();
    load_settings(1'b1, 32'h4000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 1'b1);
    push_buffer(MAX_FRAMES_DEF, 32767, 1'b0);
    push(0, 0, 1'b1);

    // --- random phases: new settings each phase, mostly short buffers
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_FRAMES) begin
      settle();
      load_settings(1'b1, pick_threshold(), pick_timeout(), pick_timeout(),
                    $urandom_range(0, 3), 1'($urandom_range(0, 1)));
      if (phase == 2) begin
        // receiver holds off while one-frame buffers keep coming, so the
        // result queue fills and the input stalls
        hold_off = HOLD_CYCLES;
        for (int i = 0; i < 48; i++) push_buffer(1, pick_cap(), 1'b1);
        sent += 48;
      end
      target = $urandom_range(80, 200);
      got    = 0;
      while (got < target) begin
        len = pick_len();
        // the last buffer of a phase is sometimes left open across the writes
        open_end = (got + len >= target) && ($urandom_range(0, 3) == 0);
        push_buffer(len, pick_cap(), !open_end);
        got += len;
      end
      sent += got;
      if ($urandom_range(0, 4) == 0) begin
        settle();
        write_reg(REG_ENABLE, 0, 1'b1);
        for (int i = 0; i < 8; i++)
          push(rand_sample(32767), rand_sample(32767), 1'($urandom_range(0, 1)));
        settle();
        write_reg(REG_ENABLE, 1, 1'b1);
      end
      phase++;
    end

    settle();
    if (mismatches == 0 && verdicts_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
